// ===== design/facmc_pkg.sv =====
package facmc_pkg;

	// default sizes
	localparam int MAX_LINES_DEF  = 16;
	localparam int SEEN_DEPTH_DEF = 256;
	localparam int ADDR_WIDTH_DEF = 28;

	// configuration port
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 5;
	localparam int CFG_LINES_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_POLICY_LRU   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LINES_IN_USE = 1'd1;
	localparam logic [CFG_LINES_W-1:0] LINES_RESET = 5'd16;

	// outcome codes
	localparam int OUTCOME_W = 2;
	localparam logic [OUTCOME_W-1:0] OUTCOME_HIT        = 2'd0;
	localparam logic [OUTCOME_W-1:0] OUTCOME_COMPULSORY = 2'd1;
	localparam logic [OUTCOME_W-1:0] OUTCOME_CAPACITY   = 2'd2;

	localparam int CNT_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEEN_SCAN,
		ST_SEEN_REC,
		ST_LINE_SCAN,
		ST_DECIDE,
		ST_SHIFT,
		ST_FINAL,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic seen_scan;
		logic seen_rec;
		logic line_scan;
		logic decide;
		logic shift;
		logic final_wr;
		logic publish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic seen_done;
		logic line_done;
		logic shift_done;
		logic out_free;
	} sts_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		sat_inc = (v == '1) ? v : v + 1'b1;
	endfunction

endpackage

// ===== design/fully_assoc_cache_miss_classifier_core.sv =====
// Steps from accept to result: seen-table scan, seen record, line scan, decide,
//   line shift, final write and publish; the scans and the shift grow with the
//   seen count, the line count and the shift length.
// Throughput: one item at a time; the seen-table scan, line scan and line shift
//   each walk a memory one entry per cycle; the next item is accepted in the
//   cycle after the result is staged, a stalled result holds the next one back.
// Reset (arst_n low): counts, counters and overflow clear, LRU policy, 16 lines;
//   the tag memories need no clearing since only filled entries are read.
module fully_assoc_cache_miss_classifier_core import facmc_pkg::*; #(
	parameter int MAX_LINES  = MAX_LINES_DEF,
	parameter int SEEN_DEPTH = SEEN_DEPTH_DEF,
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [ADDR_WIDTH-1:0] address,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUTCOME_W-1:0]  outcome,
	output logic [CNT_W-1:0]      hit_total,
	output logic [CNT_W-1:0]      miss_total,
	output logic [CNT_W-1:0]      compulsory_total,
	output logic [CNT_W-1:0]      capacity_total,
	output logic                  seen_overflow
);

	cmd_t cmd;
	sts_t sts;

	facmc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	facmc_dp #(
		.MAX_LINES  (MAX_LINES),
		.SEEN_DEPTH (SEEN_DEPTH),
		.ADDR_WIDTH (ADDR_WIDTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.address          (address),
		.cmd              (cmd),
		.sts              (sts),
		.out_stall        (out_stall),
		.out_valid        (out_valid),
		.outcome          (outcome),
		.hit_total        (hit_total),
		.miss_total       (miss_total),
		.compulsory_total (compulsory_total),
		.capacity_total   (capacity_total),
		.seen_overflow    (seen_overflow)
	);

	// an accepted item keeps the input closed until its result is staged
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input reopened right after accept");

	// at most one command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("overlapping controller commands");

	// a pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.publish |-> !(out_valid && out_stall))
		else $error("result overwritten while stalled");

	// outcome is a valid code whenever shown
	a_outcome_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outcome == OUTCOME_HIT || outcome == OUTCOME_COMPULSORY ||
		               outcome == OUTCOME_CAPACITY))
		else $error("bad outcome code");

endmodule

// ===== design/facmc_ctrl.sv =====
module facmc_ctrl import facmc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q, state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.load = in_valid;
				if (in_valid) state_d = ST_SEEN_SCAN;
			end
			ST_SEEN_SCAN: begin
				cmd.seen_scan = 1'b1;
				if (sts.seen_done) state_d = ST_SEEN_REC;
			end
			ST_SEEN_REC: begin
				cmd.seen_rec = 1'b1;
				state_d = ST_LINE_SCAN;
			end
			ST_LINE_SCAN: begin
				cmd.line_scan = 1'b1;
				if (sts.line_done) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) state_d = ST_FINAL;
			end
			ST_FINAL: begin
				cmd.final_wr = 1'b1;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				cmd.publish = sts.out_free;
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule

// ===== design/facmc_dp.sv =====
module facmc_dp import facmc_pkg::*; #(
	parameter int MAX_LINES  = MAX_LINES_DEF,
	parameter int SEEN_DEPTH = SEEN_DEPTH_DEF,
	parameter int ADDR_WIDTH = ADDR_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic [ADDR_WIDTH-1:0] address,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	input  logic                  out_stall,
	output logic                  out_valid,
	output logic [OUTCOME_W-1:0]  outcome,
	output logic [CNT_W-1:0]      hit_total,
	output logic [CNT_W-1:0]      miss_total,
	output logic [CNT_W-1:0]      compulsory_total,
	output logic [CNT_W-1:0]      capacity_total,
	output logic                  seen_overflow
);

	localparam int LIW  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
	localparam int LCW  = $clog2(MAX_LINES + 1);
	localparam int SIW  = $clog2(SEEN_DEPTH);
	localparam int SCW  = $clog2(SEEN_DEPTH + 1);
	localparam int MAXD = (SEEN_DEPTH > MAX_LINES) ? SEEN_DEPTH : MAX_LINES;
	localparam int IW   = $clog2(MAXD + 1);
	localparam int CW   = (LCW > CFG_LINES_W) ? LCW : CFG_LINES_W;

	// configuration
	logic                   policy_q;
	logic [CFG_LINES_W-1:0] lines_q;

	// item state
	logic [ADDR_WIDTH-1:0] addr_q;
	logic [IW-1:0]         idx_q;
	logic [IW-1:0]         rd_pos_q;
	logic                  pend_q;
	logic                  seen_q;
	logic                  hit_q;
	logic [LIW-1:0]        hit_pos_q;
	logic                  full_q;

	// stores and counts
	logic [ADDR_WIDTH-1:0] seen_mem [SEEN_DEPTH];
	logic [ADDR_WIDTH-1:0] line_mem [MAX_LINES];
	logic [ADDR_WIDTH-1:0] seen_rd_q;
	logic [ADDR_WIDTH-1:0] line_rd_q;
	logic [SCW-1:0]        seen_count_q;
	logic [LCW-1:0]        line_count_q;

	logic [CNT_W-1:0]      hits_q, misses_q, comp_q, cap_q;
	logic                  ovf_q;
	logic                  out_valid_q;

	logic seen_more, line_more, issue, full;
	logic [IW-1:0] idx_next;
	logic [IW-1:0] decide_start;
	logic          seen_wr;
	logic          line_wr;
	logic [LIW-1:0] line_waddr;
	logic [ADDR_WIDTH-1:0] line_wdata;

	assign seen_more = (idx_q < IW'(seen_count_q));
	assign line_more = (idx_q < IW'(line_count_q));
	assign issue     = (cmd.seen_scan && seen_more) ||
	                   ((cmd.line_scan || cmd.shift) && line_more);
	assign idx_next  = idx_q + 1'b1;

	// cache counts as full once the clamped line limit is reached
	assign full = (line_count_q >= LCW'(MAX_LINES)) ||
	              ((lines_q != '0) && (CW'(line_count_q) >= CW'(lines_q))) ||
	              ((lines_q == '0) && (line_count_q != '0));

	// a FIFO hit keeps the order, so its shift is empty
	assign decide_start = hit_q ? (policy_q ? (IW'(hit_pos_q) + 1'b1) : IW'(line_count_q)) :
	                      (full ? IW'(1) : IW'(line_count_q));

	assign sts.seen_done  = !seen_more && !pend_q;
	assign sts.line_done  = !line_more && !pend_q;
	assign sts.shift_done = !line_more && !pend_q;
	assign sts.out_free   = !out_valid_q || !out_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q <= 1'b1;
			lines_q  <= LINES_RESET;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_POLICY_LRU:   policy_q <= cfg_data[0];
				CFG_LINES_IN_USE: lines_q  <= cfg_data[CFG_LINES_W-1:0];
				default:          ;
			endcase
		end
	end

	// address latch
	always_ff @(posedge clk) begin
		if (cmd.load) addr_q <= address;
	end

	// scan index and read pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q    <= '0;
			rd_pos_q <= '0;
			pend_q   <= 1'b0;
		end else begin
			pend_q <= issue;
			if (issue) begin
				idx_q    <= idx_next;
				rd_pos_q <= idx_q;
			end else if (cmd.load || cmd.seen_rec) begin
				idx_q <= '0;
			end else if (cmd.decide) begin
				idx_q <= decide_start;
			end
		end
	end

	// seen table
	assign seen_wr = cmd.seen_rec && !seen_q && (seen_count_q < SCW'(SEEN_DEPTH));

	always_ff @(posedge clk) begin
		if (seen_wr) seen_mem[seen_count_q[SIW-1:0]] <= addr_q;
		seen_rd_q <= seen_mem[idx_q[SIW-1:0]];
	end

	// line store: shift copies one entry down, final write puts the new tag
	assign line_wr = (cmd.shift && pend_q) ||
	                 (cmd.final_wr && (!hit_q || policy_q));
	always_comb begin
		if (cmd.shift) begin
			line_waddr = LIW'(rd_pos_q - 1'b1);
			line_wdata = line_rd_q;
		end else begin
			line_waddr = (hit_q || full_q) ? LIW'(line_count_q - 1'b1) : LIW'(line_count_q);
			line_wdata = addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (line_wr) line_mem[line_waddr] <= line_wdata;
		line_rd_q <= line_mem[idx_q[LIW-1:0]];
	end

	// hit pos and flags
	always_ff @(posedge clk) begin
		if (cmd.line_scan && pend_q && !hit_q && (line_rd_q == addr_q)) begin
			hit_pos_q <= LIW'(rd_pos_q);
		end
		if (cmd.decide) full_q <= full;
	end

	// control state, counts and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q       <= 1'b0;
			hit_q        <= 1'b0;
			seen_count_q <= '0;
			line_count_q <= '0;
			hits_q       <= '0;
			misses_q     <= '0;
			comp_q       <= '0;
			cap_q        <= '0;
			ovf_q        <= 1'b0;
		end else begin
			if (cmd.load) begin
				seen_q <= 1'b0;
				hit_q  <= 1'b0;
			end
			if (cmd.seen_scan && pend_q && (seen_rd_q == addr_q)) seen_q <= 1'b1;
			if (cmd.line_scan && pend_q && (line_rd_q == addr_q)) hit_q <= 1'b1;
			if (seen_wr) seen_count_q <= seen_count_q + 1'b1;
			if (cmd.seen_rec && !seen_q && !seen_wr) ovf_q <= 1'b1;
			if (cmd.decide) begin
				if (hit_q) begin
					hits_q <= sat_inc(hits_q);
				end else begin
					misses_q <= sat_inc(misses_q);
					if (seen_q) cap_q  <= sat_inc(cap_q);
					else        comp_q <= sat_inc(comp_q);
				end
			end
			if (cmd.final_wr && !hit_q && !full_q) line_count_q <= line_count_q + 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			outcome          <= hit_q ? OUTCOME_HIT :
			                    (seen_q ? OUTCOME_CAPACITY : OUTCOME_COMPULSORY);
			hit_total        <= hits_q;
			miss_total       <= misses_q;
			compulsory_total <= comp_q;
			capacity_total   <= cap_q;
			seen_overflow    <= ovf_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
